[rtl/sha256_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 hasher: round constants, initial
// hash values, padding constants and the control word of the compression engine.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned TOTAL_W = 61;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [5:0] LAST_RND = 6'd63;
	localparam logic [2:0] LAST_IDX = 3'd7;

	localparam logic [WORD_W-1:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WORD_W-1:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic       init;
		logic       shift;
		logic [7:0] byte_val;
		logic       load;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic [2:0] sel;
	} sha256_ctl_t;

endpackage
`default_nettype wire

[rtl/sha256_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_if
// Valid/ready channels of the SHA-256 hasher: message words in, digest out.
// ----------------------------------------------------------------------------
interface sha256_msg_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface sha256_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface
`default_nettype wire

[rtl/sha256_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_engine
// Block buffer with rolling message schedule, one compression round per cycle,
// and the eight chaining words.
// ----------------------------------------------------------------------------
module sha256_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha256_pkg::sha256_ctl_t   ctl,
	output logic [31:0]               digest_word
);

	function automatic logic [31:0] ep0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] ep1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sg0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sg1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	logic [511:0] blk_q;
	logic [31:0]  wv_q [8];
	logic [31:0]  chain_q [8];

	logic [31:0] w0, w1, w9, w14, new_w;
	logic [31:0] t1, t2, ch, maj;

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign new_w = sg1(w14) + w9 + sg0(w1) + w0;

	assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1  = wv_q[7] + ep1(wv_q[4]) + ch + sha256_pkg::ROUND_K[ctl.rnd] + w0;
	assign t2  = ep0(wv_q[0]) + maj;

	assign digest_word = chain_q[ctl.sel];

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			blk_q <= {blk_q[503:0], ctl.byte_val};
		end else if (ctl.round) begin
			blk_q <= {blk_q[479:0], new_w};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			wv_q <= chain_q;
		end else if (ctl.round) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha256_pkg::INIT_H;
		end else if (ctl.init) begin
			chain_q <= sha256_pkg::INIT_H;
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + wv_q[i];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/sha256_message_hasher_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hasher_core
// SHA-256 over a byte stream, one compression round per cycle.
//
// msg channel: each word carries action and data_byte. Action 0 absorbs
// data_byte; action 1 closes the message and starts padding.
// digest channel: a finished message yields eight words, word_index 0 to 7,
// last_word set on the eighth.
// An absorb that completes a 64-byte block starts a compression: a load of the
// working words, 64 rounds, and a fold into the chaining words.
// A finish writes pad and length bytes at one per cycle (64 minus the bytes
// held, plus 64 more when the length does not fit), runs one or two
// compressions, then hands out one digest word per cycle unless stalled.
// msg.ready is high only while the sequencer is idle.
// A stalled receiver holds the digest sequence in place; the last digest word
// may still wait in the output register while the next message is absorbed.
// Reset loads the initial hash values and clears the block fill and byte count.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core (
	input  logic                     clk,
	input  logic                     arst_n,
	sha256_msg_if.sink               msg,
	sha256_digest_if.source          digest
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LOAD  = 6'b000010,
		ST_ROUND = 6'b000100,
		ST_ADD   = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t                               state_q;
	logic [5:0]                           fill_q;
	logic [sha256_pkg::TOTAL_W-1:0]       total_q;
	logic                                 finishing_q;
	logic                                 pad_first_q;
	logic                                 len_ok_q;
	logic                                 last_blk_q;
	logic [5:0]                           rnd_q;
	logic [2:0]                           idx_q;

	logic        out_vld_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_idx_q;
	logic        out_last_q;

	sha256_pkg::sha256_ctl_t ctl;
	logic [31:0] eng_word;
	logic        in_acc;
	logic        byte_wr;
	logic        len_byte;
	logic        emit_go;
	logic [7:0]  pad_byte;

	sha256_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.digest_word (eng_word)
	);

	assign msg.ready          = (state_q == ST_IDLE);
	assign digest.valid       = out_vld_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_idx_q;
	assign digest.last_word   = out_last_q;

	always_comb begin
		in_acc   = msg.valid && msg.ready;
		len_byte = !pad_first_q && len_ok_q && (fill_q >= sha256_pkg::LEN_POS);
		if (pad_first_q) begin
			pad_byte = sha256_pkg::PAD_BYTE;
		end else if (len_byte) begin
			pad_byte = total_q[sha256_pkg::TOTAL_W-1 -: 8];
		end else begin
			pad_byte = 8'h00;
		end
		byte_wr = (in_acc && !msg.action) || (state_q == ST_PAD);
		emit_go = (state_q == ST_EMIT) && (!out_vld_q || digest.ready);

		ctl          = '0;
		ctl.shift    = byte_wr;
		ctl.byte_val = (state_q == ST_PAD) ? pad_byte : msg.data_byte;
		ctl.load     = (state_q == ST_LOAD);
		ctl.round    = (state_q == ST_ROUND);
		ctl.rnd      = rnd_q;
		ctl.add      = (state_q == ST_ADD);
		ctl.sel      = idx_q;
		ctl.init     = emit_go && (idx_q == sha256_pkg::LAST_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			total_q     <= '0;
			finishing_q <= 1'b0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			last_blk_q  <= 1'b0;
			rnd_q       <= '0;
			idx_q       <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (byte_wr) begin
				fill_q <= fill_q + 6'd1;
				if (fill_q == sha256_pkg::LAST_POS) begin
					state_q <= ST_LOAD;
					if (finishing_q) begin
						if (len_ok_q) begin
							last_blk_q <= 1'b1;
						end else begin
							len_ok_q <= 1'b1;
						end
					end
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (msg.action) begin
							finishing_q <= 1'b1;
							pad_first_q <= 1'b1;
							len_ok_q    <= (fill_q < sha256_pkg::LEN_POS);
							state_q     <= ST_PAD;
						end else begin
							total_q <= total_q + {{(sha256_pkg::TOTAL_W-1){1'b0}}, 1'b1};
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (len_byte) begin
						total_q <= total_q << 8;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == sha256_pkg::LAST_RND) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (last_blk_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else if (finishing_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha256_pkg::LAST_IDX) begin
							finishing_q <= 1'b0;
							last_blk_q  <= 1'b0;
							len_ok_q    <= 1'b0;
							total_q     <= '0;
							fill_q      <= '0;
							state_q     <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (emit_go) begin
				out_vld_q <= 1'b1;
			end else if (digest.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_word_q <= eng_word;
			out_idx_q  <= idx_q;
			out_last_q <= (idx_q == sha256_pkg::LAST_IDX);
		end
	end

endmodule
`default_nettype wire
